// ===== rtl/mbb_pkg.sv =====
// Shared constants and types for the masked bitmap blitter.
package mbb_pkg;

    // Default geometry and mask size
    localparam int C_FRAME_WIDTH   = 360;
    localparam int C_FRAME_HEIGHT  = 200;
    localparam int C_MASK_DEPTH    = 65536;
    localparam int C_MAX_RECT_SIDE = 8;

    // Stream payload widths, padded to whole bytes
    localparam int C_IN_DATA_W  = 104;
    localparam int C_OUT_DATA_W = 56;

    // Field widths
    localparam int C_COORD_W  = 10;
    localparam int C_SIDE_W   = 4;
    localparam int C_COLOR_W  = 32;
    localparam int C_PADDR_W  = 17;
    localparam int C_MADDR_W  = 16;
    localparam int C_STRIDE_W = 8;

    // Signed width for clip arithmetic, covers frame sides up to 1024
    localparam int C_XY_W = 12;
    // Signed width of a mask index: 4 * (row + sy) * stride + 4 * (col + sx)
    localparam int C_MI_W = 22;

    // Reset value of the source stride register
    localparam logic [C_STRIDE_W-1:0] C_STRIDE_RESET = 8'd128;

    // Mode carried in tuser
    localparam logic C_MODE_LOAD = 1'b0;
    localparam logic C_MODE_BLIT = 1'b1;

    typedef logic signed [C_COORD_W-1:0] t_coord;
    typedef logic        [C_SIDE_W-1:0]  t_side;

endpackage

// ===== rtl/masked_bitmap_blit.sv =====
// Masked bitmap blitter: mask store, clip setup, pixel walker and output stage.
//
// Paints a solid color through a one-bit mask into a linear framebuffer.
// A load item (tuser = 0) writes one mask bit. A blit item (tuser = 1)
// passes a setup state for clipping and the two row-base multiplies, then
// takes one cycle per pixel of the clipped rectangle (up to 64) while no
// output backpressure stalls it, set by the single read port of the mask
// memory, and then drains the mask read and the held-back write that carries
// tlast. The next item is accepted once the previous blit has drained into
// the output register. Output backpressure stalls the walk. The mask memory holds no
// reset value and gets no clearing pass: entries must be loaded before a
// blit reads them. The stride register is written only while idle.
module masked_bitmap_blit #(
    parameter int FRAME_WIDTH   = mbb_pkg::C_FRAME_WIDTH,
    parameter int FRAME_HEIGHT  = mbb_pkg::C_FRAME_HEIGHT,
    parameter int MASK_DEPTH    = mbb_pkg::C_MASK_DEPTH,
    parameter int MAX_RECT_SIDE = mbb_pkg::C_MAX_RECT_SIDE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Stride register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbb_pkg::C_STRIDE_W-1:0]   i_cfg_data,    // source_stride
    // Input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // mask_address, mask_bit, dest_x, dest_y, rect_width, rect_height,
    // source_x, source_y, paint_color, zero pad
    input  logic [mbb_pkg::C_IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]                       s_axis_tuser,  // mode
    // Framebuffer writes
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pixel_address, pixel_value, zero pad
    output logic [mbb_pkg::C_OUT_DATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast   // last_write
);
    import mbb_pkg::*;

    localparam int AW  = $clog2(MASK_DEPTH);
    localparam int ASW = $clog2(FRAME_WIDTH) + 12;

    localparam logic signed [ASW-1:0]    FW_A     = ASW'(FRAME_WIDTH);
    localparam logic signed [ASW-1:0]    AREA_A   = ASW'(FRAME_WIDTH * FRAME_HEIGHT);
    localparam logic signed [C_XY_W-1:0] FW_X     = C_XY_W'(FRAME_WIDTH);
    localparam logic signed [C_XY_W-1:0] FH_X     = C_XY_W'(FRAME_HEIGHT);
    localparam logic signed [C_MI_W-1:0] DEPTH_MI = C_MI_W'(MASK_DEPTH);
    localparam t_side                    SIDE_MAX = C_SIDE_W'(MAX_RECT_SIDE);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    // Input field slices
    logic [C_MADDR_W-1:0] in_maddr;
    logic                 in_mbit;
    t_coord               in_dx, in_dy, in_sx, in_sy;
    t_side                in_w, in_h;
    logic [C_COLOR_W-1:0] in_color;

    assign in_maddr = s_axis_tdata[15:0];
    assign in_mbit  = s_axis_tdata[16];
    assign in_dx    = s_axis_tdata[26:17];
    assign in_dy    = s_axis_tdata[36:27];
    assign in_w     = s_axis_tdata[40:37];
    assign in_h     = s_axis_tdata[44:41];
    assign in_sx    = s_axis_tdata[54:45];
    assign in_sy    = s_axis_tdata[64:55];
    assign in_color = s_axis_tdata[96:65];

    // Registers
    logic [1:0]            r_state;
    logic [C_STRIDE_W-1:0] r_stride;
    t_coord                r_x, r_y, r_sx, r_sy;
    t_side                 r_w, r_h, r_cw, r_ch, r_col, r_row;
    logic [C_COLOR_W-1:0]  r_color;
    logic signed [C_MI_W-1:0] r_mi, r_row_mi;
    logic signed [ASW-1:0] r_addr, r_row_addr;
    logic                  r_mask_mem [MASK_DEPTH];
    logic                  r_mask_q;
    logic                  r_s2_valid, r_s2_ok;
    logic [C_PADDR_W-1:0]  r_s2_addr;
    logic                  r_pend_valid;
    logic [C_PADDR_W-1:0]  r_pend_addr;
    logic                  r_out_valid, r_out_last;
    logic [C_PADDR_W-1:0]  r_out_addr;
    logic [C_COLOR_W-1:0]  r_out_color;

    logic in_fire;
    assign s_axis_tready = (r_state == S_IDLE) && !r_s2_valid && !r_pend_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    // Take a stride write only while no blit is in flight
    assign o_cfg_ready   = (r_state == S_IDLE) && !r_s2_valid && !r_pend_valid;

    // Setup: clip, reject, row bases
    logic signed [C_XY_W-1:0] xe, ye, xr, yb;
    logic                     reject;
    t_side                    n_cw, n_ch;
    logic signed [ASW-1:0]    x_a, y_a, n_row_addr;
    logic signed [C_MI_W-1:0] sx_m, sy_m, st_m, n_row_mi, mi_step;

    assign xe     = C_XY_W'(r_x);
    assign ye     = C_XY_W'(r_y);
    assign xr     = xe + C_XY_W'(r_w);
    assign yb     = ye + C_XY_W'(r_h);
    assign n_cw   = (xr > FW_X) ? C_SIDE_W'(FW_X - xe) : r_w;
    assign n_ch   = (yb > FH_X) ? C_SIDE_W'(FH_X - ye) : r_h;
    assign reject = (xe >= FW_X) || (xr <= 0) || (ye >= FH_X) || (yb <= 0)
                 || (n_cw == '0) || (n_ch == '0);

    assign x_a        = ASW'(r_x);
    assign y_a        = ASW'(r_y);
    assign n_row_addr = y_a * FW_A + x_a;

    assign sx_m     = C_MI_W'(r_sx);
    assign sy_m     = C_MI_W'(r_sy);
    assign st_m     = C_MI_W'(r_stride);
    assign n_row_mi = ((sy_m * st_m) <<< 2) + (sx_m <<< 2);
    assign mi_step  = st_m <<< 2;

    // Pixel checks and pipeline control
    logic mi_ok, addr_ok, col_end, row_end;
    logic out_free, s2_hit, s2_go, advance, issue, flush;

    assign mi_ok    = !r_mi[C_MI_W-1] && (r_mi < DEPTH_MI);
    assign addr_ok  = !r_addr[ASW-1] && (r_addr < AREA_A);
    assign col_end  = (r_col == r_cw - 1'b1);
    assign row_end  = (r_row == r_ch - 1'b1);

    assign out_free = !r_out_valid || m_axis_tready;
    assign s2_hit   = r_s2_valid && r_s2_ok && r_mask_q;
    assign s2_go    = !s2_hit || !r_pend_valid || out_free;
    assign advance  = !r_s2_valid || s2_go;
    assign issue    = (r_state == S_WALK) && advance;
    assign flush    = (r_state == S_IDLE) && !r_s2_valid && r_pend_valid && out_free;

    // Mask memory: load writes, walker reads
    always_ff @(posedge i_clk) begin
        if (in_fire && (s_axis_tuser[0] == C_MODE_LOAD)
            && ({1'b0, in_maddr} < (C_MADDR_W + 1)'(MASK_DEPTH))) begin
            r_mask_mem[in_maddr[AW-1:0]] <= in_mbit;
        end
        if (issue && mi_ok) begin
            r_mask_q <= r_mask_mem[r_mi[AW-1:0]];
        end
    end

    // Stride register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= C_STRIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stride <= i_cfg_data;
        end
    end

    // Latch blit fields
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x     <= in_dx;
            r_y     <= in_dy;
            r_sx    <= in_sx;
            r_sy    <= in_sy;
            r_w     <= (in_w > SIDE_MAX) ? SIDE_MAX : in_w;
            r_h     <= (in_h > SIDE_MAX) ? SIDE_MAX : in_h;
            r_color <= in_color;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (s_axis_tuser[0] == C_MODE_BLIT)) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= reject ? S_IDLE : S_WALK;
                end
                S_WALK: begin
                    if (issue && col_end && row_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Walk counters and running index and address
    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_cw       <= n_cw;
            r_ch       <= n_ch;
            r_col      <= '0;
            r_row      <= '0;
            r_mi       <= n_row_mi;
            r_row_mi   <= n_row_mi;
            r_addr     <= n_row_addr;
            r_row_addr <= n_row_addr;
        end else if (issue) begin
            if (col_end) begin
                r_col      <= '0;
                r_row      <= r_row + 1'b1;
                r_row_mi   <= r_row_mi + mi_step;
                r_mi       <= r_row_mi + mi_step;
                r_row_addr <= r_row_addr + FW_A;
                r_addr     <= r_row_addr + FW_A;
            end else begin
                r_col  <= r_col + 1'b1;
                r_mi   <= r_mi + C_MI_W'(4);
                r_addr <= r_addr + ASW'(1);
            end
        end
    end

    // Mask read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= (r_state == S_WALK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_ok   <= mi_ok && addr_ok;
            r_s2_addr <= r_addr[C_PADDR_W-1:0];
        end
    end

    // Hold back the latest write until the next one or the end of the blit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (s2_hit && s2_go) begin
            r_pend_valid <= 1'b1;
        end else if (flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_hit && s2_go) begin
            r_pend_addr <= r_s2_addr;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((s2_hit && r_pend_valid && out_free) || flush) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((s2_hit && r_pend_valid && out_free) || flush) begin
            r_out_addr  <= r_pend_addr;
            r_out_color <= r_color;
            r_out_last  <= flush;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(C_OUT_DATA_W - C_PADDR_W - C_COLOR_W){1'b0}},
                            r_out_color, r_out_addr};

`ifndef SYNTH
    // Walk counters stay inside the clipped rectangle
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_col < r_cw) && (r_row < r_ch)
            && (r_cw <= SIDE_MAX) && (r_ch <= SIDE_MAX))
        else $error("walk counter outside clipped rectangle");

    // Setup is left again in the next cycle
    a_setup_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |=> (r_state != S_SETUP))
        else $error("setup state held");

    // A stalled hit keeps its address and mask data
    a_hit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_hit && !s2_go) |=> r_s2_valid && $stable(r_s2_addr) && $stable(r_mask_q))
        else $error("stalled mask hit lost");

    // No new item while a write is still held back
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && (r_state == S_IDLE) && !r_s2_valid && !out_free
            |=> r_pend_valid && (r_state == S_IDLE))
        else $error("held-back write dropped");
`endif

endmodule
